>>> rtl/oets_pkg.sv
package oets_pkg;

   // capacity of the cell row and derived widths
   localparam int MAX_ELEMENTS = 16;
   localparam int VAL_W = 32;
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // control broadcast from the controller to every cell
   typedef struct packed {
      logic             load;
      logic             shift;
      logic             sort;
      logic             phase_odd;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

endpackage

>>> rtl/oets_cell.sv
module oets_cell (
   input  logic                                 clock,
   input  oets_pkg::cell_ctrl_type              ctrl,
   input  logic [oets_pkg::IDX_W-1:0]           cell_index,
   input  logic signed [oets_pkg::VAL_W-1:0]    load_value,
   input  logic signed [oets_pkg::VAL_W-1:0]    left_value,
   input  logic signed [oets_pkg::VAL_W-1:0]    right_value,
   input  logic                                 left_gt,
   output logic signed [oets_pkg::VAL_W-1:0]    value,
   output logic                                 right_gt
);

   logic signed [oets_pkg::VAL_W-1:0] value_ff;
   logic signed [oets_pkg::VAL_W-1:0] value_in;
   logic                              pair_left;
   logic [oets_pkg::CNT_W-1:0]        index_wide;

   assign index_wide = oets_pkg::CNT_W'(cell_index);

   // this cell is the left side of a live pair in the current phase
   assign pair_left = ctrl.sort && (cell_index[0] == ctrl.phase_odd)
                      && ((index_wide + oets_pkg::CNT_W'(1)) < ctrl.count);
   assign right_gt  = pair_left && (value_ff > right_value);

   // load, shift toward the output, or compare and swap
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         if (index_wide == ctrl.count) begin
            value_in = load_value;
         end
      end else if (ctrl.shift) begin
         value_in = right_value;
      end else if (right_gt) begin
         value_in = right_value;
      end else if (left_gt) begin
         value_in = left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> rtl/odd_even_transposition_sort_top.sv
// Odd-even transposition sorter for sets of up to 16 signed 32-bit values. Each
// req beat loads one value into a row of cells; the beat with req_last_item
// closes the set, and values beyond the row's capacity are dropped and flagged
// on every result of that set. The row then sorts in place, one odd or even
// compare-and-swap phase per cycle, stopping after an odd+even pass with no
// swap. Results are shifted out of cell 0, one rsp beat per cycle while
// rsp_ready is high, ascending, with rsp_last_result on the final one. The
// block takes no new set until the last result is taken.
module odd_even_transposition_sort_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [oets_pkg::VAL_W-1:0]    req_value,
   input  logic                                 req_last_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [oets_pkg::VAL_W-1:0]    rsp_sorted_value,
   output logic                                 rsp_last_result,
   output logic                                 rsp_overflowed
);

   localparam int N = oets_pkg::MAX_ELEMENTS;

   oets_pkg::state_type         state_ff, state_in;
   logic [oets_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic                        phase_odd_ff, phase_odd_in;
   logic                        pass_swap_ff, pass_swap_in;
   oets_pkg::cell_ctrl_type     ctrl;
   logic                        req_beat, rsp_beat, any_swap;

   logic signed [oets_pkg::VAL_W-1:0] cell_value [N];
   logic signed [oets_pkg::VAL_W-1:0] left_val   [N];
   logic signed [oets_pkg::VAL_W-1:0] right_val  [N];
   logic [N-1:0]                      gt_vec;
   logic [N-1:0]                      left_gt_vec;

   assign req_ready = (state_ff == oets_pkg::ST_LOAD);
   assign rsp_valid = (state_ff == oets_pkg::ST_EMIT);
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;
   assign any_swap  = |gt_vec;

   // broadcast control to the row
   always_comb begin
      ctrl.load      = req_beat && (count_ff < oets_pkg::CNT_W'(N));
      ctrl.shift     = rsp_beat;
      ctrl.sort      = (state_ff == oets_pkg::ST_SORT);
      ctrl.phase_odd = phase_odd_ff;
      ctrl.count     = count_ff;
   end

   // neighbor wiring of the cell row
   for (genvar k = 0; k < N; k++) begin : g_cell
      if (k == 0) begin : g_first
         assign left_val[k]    = '0;
         assign left_gt_vec[k] = 1'b0;
      end else begin : g_mid
         assign left_val[k]    = cell_value[k-1];
         assign left_gt_vec[k] = gt_vec[k-1];
      end
      if (k == N - 1) begin : g_last
         assign right_val[k] = '0;
      end else begin : g_inner
         assign right_val[k] = cell_value[k+1];
      end

      oets_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (oets_pkg::IDX_W'(k)),
         .load_value  (req_value),
         .left_value  (left_val[k]),
         .right_value (right_val[k]),
         .left_gt     (left_gt_vec[k]),
         .value       (cell_value[k]),
         .right_gt    (gt_vec[k])
      );
   end

   // controller next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      phase_odd_in = phase_odd_ff;
      pass_swap_in = pass_swap_ff;
      unique case (state_ff)
         oets_pkg::ST_LOAD: begin
            if (req_beat) begin
               if (ctrl.load) begin
                  count_in = count_ff + oets_pkg::CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_item) begin
                  state_in     = oets_pkg::ST_SORT;
                  phase_odd_in = 1'b1;
                  pass_swap_in = 1'b0;
               end
            end
         end
         oets_pkg::ST_SORT: begin
            if (phase_odd_ff) begin
               pass_swap_in = any_swap;
               phase_odd_in = 1'b0;
            end else if (!(pass_swap_ff || any_swap)) begin
               state_in = oets_pkg::ST_EMIT;
            end else begin
               pass_swap_in = 1'b0;
               phase_odd_in = 1'b1;
            end
         end
         oets_pkg::ST_EMIT: begin
            if (rsp_beat) begin
               count_in = count_ff - oets_pkg::CNT_W'(1);
               if (count_ff == oets_pkg::CNT_W'(1)) begin
                  state_in = oets_pkg::ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = oets_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oets_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         phase_odd_ff <= 1'b1;
         pass_swap_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         phase_odd_ff <= phase_odd_in;
         pass_swap_ff <= pass_swap_in;
      end
   end

   // result beat comes straight from cell 0
   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_result  = (count_ff == oets_pkg::CNT_W'(1));
   assign rsp_overflowed   = ovf_ff;

   // a result is never offered from an empty row
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("result offered with empty row");

   // row never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= oets_pkg::CNT_W'(N))
      else $error("element count beyond capacity");

   // the final result returns the block to loading with the flag cleared
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_last_result) |=> (req_ready && !ovf_ff && count_ff == '0))
      else $error("block not reopened after final result");

   // an even phase that ends a phase pair with no swap moves the block to emission
   a_sorted_on_emit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.sort && !phase_odd_ff && !pass_swap_ff && !any_swap) |=> rsp_valid)
      else $error("sort finished without entering emit");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;

   // one expected beat on the result channel
   typedef struct {
      logic signed [oets_pkg::VAL_W-1:0] value;
      logic                              last;
      logic                              ovf;
   } sorted_beat_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [oets_pkg::VAL_W-1:0] req_value = '0;
   logic                              req_last_item = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [oets_pkg::VAL_W-1:0] rsp_sorted_value;
   logic                              rsp_last_result;
   logic                              rsp_overflowed;

   // predictor state: the set being gathered
   logic signed [oets_pkg::VAL_W-1:0] held_set [oets_pkg::MAX_ELEMENTS];
   int                                held_count = 0;
   bit                                held_dropped = 1'b0;
   sorted_beat_type                   expected_sorted [$];

   int error_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   odd_even_transposition_sort_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // brick sort of the held set: odd pairs, then even pairs, until a quiet pass
   function automatic void sort_held_set(input int n);
      logic signed [oets_pkg::VAL_W-1:0] t;
      bit                                moved;
      int                                start;
      int                                k;
      moved = 1'b1;
      while (moved) begin
         moved = 1'b0;
         for (start = 1; start >= 0; start--) begin
            for (k = start; k + 1 < n; k += 2) begin
               if (held_set[k] > held_set[k+1]) begin
                  t             = held_set[k];
                  held_set[k]   = held_set[k+1];
                  held_set[k+1] = t;
                  moved         = 1'b1;
               end
            end
         end
      end
   endfunction

   // fold one accepted element into the set; a closing element yields the sorted set
   function automatic void take_element(input logic signed [oets_pkg::VAL_W-1:0] v,
                                        input logic last);
      sorted_beat_type beat;
      int              k;
      if (held_count < oets_pkg::MAX_ELEMENTS) begin
         held_set[held_count] = v;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (last) begin
         sort_held_set(held_count);
         for (k = 0; k < held_count; k++) begin
            beat.value = held_set[k];
            beat.last  = (k + 1 == held_count);
            beat.ovf   = held_dropped;
            expected_sorted.push_back(beat);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endfunction

   // watch both channels: input beats feed the predictor, result beats get checked
   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            take_element(req_value, req_last_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_sorted.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d", rsp_sorted_value));
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_sorted_value !== want.value)
                  report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                            rsp_sorted_value, want.value));
               if (rsp_last_result !== want.last)
                  report_mismatch($sformatf("last_result %b, expected %b",
                                            rsp_last_result, want.last));
               if (rsp_overflowed !== want.ovf)
                  report_mismatch($sformatf("overflowed %b, expected %b",
                                            rsp_overflowed, want.ovf));
            end
         end
      end
   end

   // send one element, with optional idle cycles in front; valid stays up after the beat
   task automatic send_element(input logic signed [oets_pkg::VAL_W-1:0] v, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_sorted.size() != 0);
   endtask

   // value mix: full range, narrow range with many repeats, the extremes, and -1000, 0 or 1000
   function automatic logic signed [oets_pkg::VAL_W-1:0] pick_value();
      logic signed [oets_pkg::VAL_W-1:0] v;
      case ($urandom_range(9)) inside
         [0:4]: v = $urandom;
         [5:6]: v = $signed($urandom_range(8)) - 4;
         7: begin
            case ($urandom_range(3))
               0:       v = {1'b1, {(oets_pkg::VAL_W-1){1'b0}}};
               1:       v = {1'b0, {(oets_pkg::VAL_W-1){1'b1}}};
               2:       v = '0;
               default: v = '1;
            endcase
         end
         default: v = $signed($urandom_range(2)) * 32'sd1000 - 32'sd1000;
      endcase
      return v;
   endfunction

   // descending order with the extremes and a repeated minimum
   task automatic test_extremes();
      send_element(32'sh7fffffff, 1'b0);
      send_element(32'sd1, 1'b0);
      send_element(32'sd0, 1'b0);
      send_element(-32'sd1, 1'b0);
      send_element(32'sh80000000, 1'b0);
      send_element(32'sh80000000, 1'b1);
      wait_drained();
   endtask

   // a set of one element
   task automatic test_single_element();
      send_element(-32'sd12345, 1'b1);
      wait_drained();
   endtask

   // full store, then a dropped element and a dropped closing element
   task automatic test_overflow();
      int k;
      for (k = 0; k < oets_pkg::MAX_ELEMENTS; k++)
         send_element(pick_value(), 1'b0);
      send_element(pick_value(), 1'b0);
      send_element(pick_value(), 1'b1);
      wait_drained();
   endtask

   // random sets under one idling mix
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_budget);
      int sent;
      int set_size;
      int k;
      sent               = 0;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (sent < item_budget) begin
         case ($urandom_range(9))
            0:       set_size = 1;
            7:       set_size = oets_pkg::MAX_ELEMENTS;
            8:       set_size = $urandom_range(oets_pkg::MAX_ELEMENTS + 4,
                                               oets_pkg::MAX_ELEMENTS + 1);
            default: set_size = $urandom_range(oets_pkg::MAX_ELEMENTS, 2);
         endcase
         for (k = 0; k < set_size; k++)
            send_element(pick_value(), k == set_size - 1);
         sent += set_size;
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_single_element();
      test_overflow();
      test_random_traffic(0, 0, 90);
      test_random_traffic(66, 0, 90);
      test_random_traffic(0, 66, 90);
      test_random_traffic(8, 8, 90);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_sorted.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_sorted.size()));
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/oets_pkg.sv
rtl/oets_cell.sv
rtl/odd_even_transposition_sort_top.sv
tb/sv/tb_top.sv
